// File: rtl/table_linear_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table interpolator
// Shared assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define TLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// Table interpolator package
// Shared types, codes and command/status structs.
// ----------------------------------------------------------------------------
package tli_pkg;
  localparam int QW = 48;
  localparam int AW = 32;
  localparam int TW = 34;

  localparam logic [1:0] RANGE_IN    = 2'd0;
  localparam logic [1:0] RANGE_BELOW = 2'd1;
  localparam logic [1:0] RANGE_ABOVE = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_CHK0, ST_RDL, ST_CHKL, ST_SCAN, ST_SCHK,
    ST_RDLO, ST_RDHI, ST_DIV, ST_DONE, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_ROW0, RD_LAST, RD_SCAN, RD_LO, RD_HI
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    cap_q;
    rd_sel_t rd;
    logic    cap0;
    logic    capl;
    logic    cap_lo;
    logic    cap_hi;
    logic    scan_init;
    logic    scan_step;
    logic    div_start;
    logic    res_row0;
    logic    res_last;
    logic    res_interp;
  } cmd_t;

  typedef struct packed {
    logic below0;
    logic ge_last;
    logic scan_hit;
    logic div_busy;
  } sts_t;
endpackage

// File: rtl/tli_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for query/load words and result words.
// ----------------------------------------------------------------------------
interface tli_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  row_index;
  logic signed [31:0] altitude;
  logic [47:0] temperature_value;
  logic [47:0] density_value;
  logic [47:0] pressure_value;
  logic [47:0] sound_speed_value;
  modport source(output valid, mode, row_index, altitude, temperature_value,
                 density_value, pressure_value, sound_speed_value, input ready);
  modport sink(input valid, mode, row_index, altitude, temperature_value,
               density_value, pressure_value, sound_speed_value, output ready);
endinterface

interface tli_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] temperature_out;
  logic [47:0] density_out;
  logic [47:0] pressure_out;
  logic [47:0] sound_speed_out;
  logic [1:0]  range_status;
  modport source(output valid, temperature_out, density_out, pressure_out,
                 sound_speed_out, range_status, input ready);
  modport sink(input valid, temperature_out, density_out, pressure_out,
               sound_speed_out, range_status, output ready);
endinterface

// File: rtl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// Table interpolator controller
// Sequences row checks, the linear scan and the divide, and the handshake.
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tli_pkg::sts_t sts,
  output tli_pkg::cmd_t cmd
);
  import tli_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd = RD_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.cap_q = 1'b1;
            state_nxt = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        cmd.rd = RD_ROW0;
        state_nxt = ST_CHK0;
      end
      ST_CHK0: begin
        cmd.cap0 = 1'b1;
        state_nxt = ST_RDL;
      end
      ST_RDL: begin
        if (sts.below0) begin
          cmd.res_row0 = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cmd.rd = RD_LAST;
          state_nxt = ST_CHKL;
        end
      end
      ST_CHKL: begin
        cmd.capl = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.ge_last) begin
          cmd.res_last = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cmd.rd = RD_SCAN;
          state_nxt = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (sts.scan_hit) begin
          state_nxt = ST_RDLO;
        end else begin
          cmd.scan_step = 1'b1;
          cmd.rd = RD_SCAN;
          state_nxt = ST_SCHK;
        end
      end
      ST_RDLO: begin
        cmd.rd = RD_LO;
        state_nxt = ST_RDHI;
      end
      ST_RDHI: begin
        cmd.rd = RD_HI;
        cmd.cap_lo = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.cap_hi = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.div_busy) begin
          cmd.res_interp = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/tli_datapath.sv
// ----------------------------------------------------------------------------
// Table interpolator datapath
// Row memory, scan pointer, bounds and four shift-subtract mul-div units.
// ----------------------------------------------------------------------------
module tli_datapath #(
  parameter int MAX_ROWS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tli_pkg::cmd_t              cmd,
  output tli_pkg::sts_t              sts,
  input  logic [7:0]                 in_row_index,
  input  logic signed [31:0]         in_altitude,
  input  logic [47:0]                in_temperature,
  input  logic [47:0]                in_density,
  input  logic [47:0]                in_pressure,
  input  logic [47:0]                in_sound_speed,
  input  logic [8:0]                 point_count,
  output logic [47:0]                res_temperature,
  output logic [47:0]                res_density,
  output logic [47:0]                res_pressure,
  output logic [47:0]                res_sound_speed,
  output logic [1:0]                 res_status
);
  import tli_pkg::*;

  localparam int IW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int RW = AW + 4 * QW;

  logic [RW-1:0] mem [MAX_ROWS];
  logic [RW-1:0] rd_r;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] scan_r, scan_nxt;
  logic signed [AW-1:0] qalt_r;
  logic [RW-1:0] lo_row_r;
  logic [RW-1:0] res_r;
  logic [1:0]    status_r;
  logic          below_r, ge_r, eq_r;
  logic signed [AW-1:0] rd_alt;
  logic [TW-1:0] t_r, d_r;
  logic [TW+1:0] d1, d2;
  logic [TW:0]   rem_r [4];
  logic [QW-1:0] m_r [4];
  logic [QW-1:0] quo_r [4];
  logic          neg_r [4];
  logic [5:0]    bit_r;
  logic          busy_r;
  logic [CW-1:0] n_eff;
  logic          idx_ok;

  assign rd_alt = rd_r[RW-1 -: AW];
  assign d1 = (TW+2)'(d_r);
  assign d2 = (TW+2)'({d_r, 1'b0});

  always_comb begin
    scan_nxt = cmd.scan_step ? scan_r + IW'(1) : scan_r;
    if (point_count == 9'd0) begin
      n_eff = CW'(1);
    end else if (CW'(point_count) > CW'(MAX_ROWS) || 32'(point_count) > MAX_ROWS) begin
      n_eff = CW'(MAX_ROWS);
    end else begin
      n_eff = CW'(point_count);
    end
    last_idx = IW'(n_eff - CW'(1));
    idx_ok = 32'(in_row_index) < MAX_ROWS;
    case (cmd.rd)
      RD_ROW0: rd_addr = '0;
      RD_LAST: rd_addr = last_idx;
      RD_SCAN: rd_addr = scan_nxt;
      RD_LO:   rd_addr = scan_r - IW'(1);
      RD_HI:   rd_addr = scan_r;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_q) begin
      qalt_r <= in_altitude;
    end
    if (cmd.load) begin
      if (idx_ok) begin
        mem[IW'(in_row_index)] <= {in_altitude, in_temperature, in_density,
                                   in_pressure, in_sound_speed};
      end
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      if (cmd.scan_init) begin
        scan_r <= IW'(1);
      end else begin
        scan_r <= scan_nxt;
      end
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        bit_r  <= 6'(QW - 1);
      end else if (busy_r) begin
        if (bit_r == 6'd0) begin
          busy_r <= 1'b0;
        end else begin
          bit_r <= bit_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      below_r <= rd_alt > qalt_r;
      res_r   <= rd_r;
    end
    if (cmd.capl) begin
      ge_r <= qalt_r >= rd_alt;
      eq_r <= qalt_r == rd_alt;
      res_r <= rd_r;
    end
    if (cmd.cap_lo) begin
      lo_row_r <= rd_r;
      t_r <= TW'(35'(signed'(qalt_r)) - 35'(signed'(rd_alt)));
    end
    if (cmd.cap_hi) begin
      d_r <= TW'(35'(signed'(rd_alt)) - 35'(signed'(lo_row_r[RW-1 -: AW])));
    end
    if (cmd.res_row0) begin
      status_r <= RANGE_BELOW;
    end
    if (cmd.res_last) begin
      status_r <= eq_r ? RANGE_IN : RANGE_ABOVE;
      if (!eq_r) begin
        res_r[2*QW +: QW] <= '0;
      end
    end
    if (cmd.res_interp) begin
      status_r <= RANGE_IN;
      for (int k = 0; k < 4; k++) begin
        res_r[k*QW +: QW] <= neg_r[k] ? lo_row_r[k*QW +: QW] - quo_r[k]
                                      : lo_row_r[k*QW +: QW] + quo_r[k];
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_md
    logic [QW-1:0] a_q, b_q;
    logic [TW+1:0] r_sh;
    assign a_q = lo_row_r[k*QW +: QW];
    assign b_q = rd_r[k*QW +: QW];
    always_comb begin
      r_sh = {rem_r[k], 1'b0} + ((m_r[k][bit_r]) ? (TW+2)'(t_r) : '0);
    end
    always_ff @(posedge clk) begin
      if (cmd.div_start) begin
        neg_r[k] <= b_q < a_q;
        m_r[k]   <= (b_q >= a_q) ? b_q - a_q : a_q - b_q;
        rem_r[k] <= '0;
        quo_r[k] <= '0;
      end else if (busy_r) begin
        if (r_sh >= d2) begin
          rem_r[k] <= (TW+1)'(r_sh - d2);
          quo_r[k] <= {quo_r[k][QW-2:0], 1'b0} + QW'(2);
        end else if (r_sh >= d1) begin
          rem_r[k] <= (TW+1)'(r_sh - d1);
          quo_r[k] <= {quo_r[k][QW-2:0], 1'b1};
        end else begin
          rem_r[k] <= (TW+1)'(r_sh);
          quo_r[k] <= {quo_r[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign sts.below0   = below_r;
  assign sts.ge_last  = ge_r;
  assign sts.scan_hit = rd_alt > qalt_r;
  assign sts.div_busy = busy_r | cmd.div_start;

  assign res_temperature = res_r[3*QW +: QW];
  assign res_density     = res_r[2*QW +: QW];
  assign res_pressure    = res_r[QW +: QW];
  assign res_sound_speed = res_r[0 +: QW];
  assign res_status      = status_r;
endmodule

// File: rtl/table_linear_interpolator_unit.sv
// Sequence: a load writes its row while idle; a query checks row 0, then the
// last row, then steps a linear scan of the row memory (one row per cycle) to
// the bracketing pair, reads both rows and runs the 48-step multiply-divide.
// Flow: one query at a time; no new word is taken until its result is accepted.
// Reset: synchronous, active low; clears control and sets point_count to 1.
// ----------------------------------------------------------------------------
// Table interpolator top level
// Piecewise linear interpolation over a loaded altitude table.
// ----------------------------------------------------------------------------
`include "table_linear_interpolator_unit_macros.svh"
module table_linear_interpolator_unit #(
  parameter int MAX_ROWS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  tli_in_if.sink    in_ch,
  tli_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata
);
  import tli_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [8:0] point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 9'd1;
    end else if (cfg_we) begin
      point_count_r <= cfg_wdata;
    end
  end

  tli_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_mode(in_ch.mode), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  tli_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_row_index(in_ch.row_index), .in_altitude(in_ch.altitude),
    .in_temperature(in_ch.temperature_value), .in_density(in_ch.density_value),
    .in_pressure(in_ch.pressure_value), .in_sound_speed(in_ch.sound_speed_value),
    .point_count(point_count_r),
    .res_temperature(out_ch.temperature_out), .res_density(out_ch.density_out),
    .res_pressure(out_ch.pressure_out), .res_sound_speed(out_ch.sound_speed_out),
    .res_status(out_ch.range_status)
  );

  `TLI_ASSERT_IMPL(a_excl, clk, rst_n, out_ch.valid, !in_ch.ready)
  `TLI_ASSERT_NEXT(a_load_idle, clk, rst_n, in_ch.valid && in_ch.ready && !in_ch.mode, in_ch.ready)
  `TLI_ASSERT_IMPL(a_status, clk, rst_n, out_ch.valid, out_ch.range_status != 2'd3)
endmodule
